// ===== hw/rtl/pctd_pkg.sv =====
// Shared types and constants of the prefix code table decoder.
package pctd_pkg;

    // Field widths of the stream words
    localparam int ACTION_W    = 2;
    localparam int INDEX_W     = 6;
    localparam int SYMBOL_W    = 8;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int S_TDATA_W   = 56;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;

    // Default sizes
    localparam int TABLE_DEPTH_DEF  = 64;
    localparam int MAX_CODE_LEN_DEF = 32;

    // Item kinds carried in the input tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_DECODE = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    // One code table entry
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic [CODE_W-1:0]   code;
        logic [LEN_W-1:0]    length;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // write the incoming entry
        logic clear;   // empty the pending code
        logic start;   // append the code bit and rewind the scan
        logic rd;      // read the table entry at the scan pointer
        logic finish;  // capture match or overflow, empty the pending code
        logic push;    // move the captured result to the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic match;     // entry read last cycle equals the pending code
        logic scan_end;  // every entry read and compared
        logic at_limit;  // pending code holds the maximum number of bits
    } t_status;

endpackage

// ===== hw/rtl/pctd_datapath.sv =====
// Datapath of the prefix code table decoder: code table, pending code, scan and result.
module pctd_datapath #(
    parameter int TABLE_DEPTH  = pctd_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_CODE_LEN = pctd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pctd_pkg::t_cmd                i_cmd,
    output pctd_pkg::t_status             o_status,
    input  logic [pctd_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [pctd_pkg::SYMBOL_W-1:0] i_entry_symbol,
    input  logic [pctd_pkg::CODE_W-1:0]   i_entry_code,
    input  logic [pctd_pkg::LEN_W-1:0]    i_entry_length,
    input  logic                          i_code_bit,
    output logic                          o_symbol_valid,
    output logic [pctd_pkg::SYMBOL_W-1:0] o_symbol,
    output logic                          o_overflow
);
    import pctd_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int AW    = ((IDX_W > INDEX_W) ? IDX_W : INDEX_W) + 1;
    localparam int PL_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int CMP_W = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

    // Table storage and per-entry valid bits
    t_entry                   r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   r_valid;

    // Pending code
    logic [MAX_CODE_LEN-1:0]  r_pend_code;
    logic [PL_W-1:0]          r_pend_len;

    // Scan pipeline
    logic [CNT_W-1:0]         r_scan_cnt;
    t_entry                   r_rd_q;
    logic                     r_rd_vld;
    logic                     r_rd_live;

    // Captured result and output register
    logic [SYMBOL_W-1:0]      r_fnd_sym;
    logic                     r_fnd_ovf;
    logic [SYMBOL_W-1:0]      r_out_sym;
    logic                     r_out_ovf;

    logic [AW-1:0]            w_idx_ext;
    logic                     w_in_range;
    logic [IDX_W-1:0]         w_waddr;
    logic [IDX_W-1:0]         w_raddr;
    logic [CODE_W:0]          w_mask;
    t_entry                   w_new_entry;
    logic [MAX_CODE_LEN:0]    w_shifted;
    logic [CMP_W-1:0]         w_pend_ext;
    logic [CMP_W-1:0]         w_code_ext;
    logic                     w_match;

    // Decode the load address and mask code bits at and above the length
    assign w_idx_ext   = AW'(i_entry_index);
    assign w_in_range  = (w_idx_ext < AW'(TABLE_DEPTH));
    assign w_waddr     = w_idx_ext[IDX_W-1:0];
    assign w_raddr     = r_scan_cnt[IDX_W-1:0];
    assign w_mask      = ((CODE_W+1)'(1) << i_entry_length) - (CODE_W+1)'(1);
    assign w_new_entry = '{symbol: i_entry_symbol,
                           code:   i_entry_code & w_mask[CODE_W-1:0],
                           length: i_entry_length};
    assign w_shifted   = {r_pend_code, i_code_bit};

    // Compare the entry read last cycle against the pending code
    assign w_pend_ext = CMP_W'(r_pend_code);
    assign w_code_ext = CMP_W'(r_rd_q.code);
    assign w_match    = r_rd_live && r_rd_vld
                        && (r_rd_q.length == LEN_W'(r_pend_len))
                        && (w_code_ext == w_pend_ext);

    // Last entry is under compare once the pointer has run past the table
    assign o_status.match    = w_match;
    assign o_status.scan_end = (r_scan_cnt == CNT_W'(TABLE_DEPTH)) && r_rd_live;
    assign o_status.at_limit = (r_pend_len == PL_W'(MAX_CODE_LEN));

    // Write loaded entries and read one entry per scan step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_in_range) begin
            r_mem[w_waddr] <= w_new_entry;
        end
        if (i_cmd.rd) begin
            r_rd_q <= r_mem[w_raddr];
        end
    end

    // Hold valid bits, pending code and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pend_code <= '0;
            r_pend_len  <= '0;
            r_scan_cnt  <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_live   <= 1'b0;
        end else begin
            r_rd_live <= i_cmd.rd;
            if (i_cmd.load && w_in_range) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_rd_vld   <= r_valid[w_raddr];
                r_scan_cnt <= r_scan_cnt + CNT_W'(1);
            end
            if (i_cmd.start) begin
                r_pend_code <= w_shifted[MAX_CODE_LEN-1:0];
                r_pend_len  <= r_pend_len + PL_W'(1);
                r_scan_cnt  <= '0;
            end
            if (i_cmd.clear || i_cmd.finish) begin
                r_pend_code <= '0;
                r_pend_len  <= '0;
            end
        end
    end

    // Capture the scan outcome, then move it to the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_fnd_sym <= w_match ? r_rd_q.symbol : '0;
            r_fnd_ovf <= !w_match;
        end
        if (i_cmd.push) begin
            r_out_sym <= r_fnd_sym;
            r_out_ovf <= r_fnd_ovf;
        end
    end

    assign o_symbol_valid = !r_out_ovf;
    assign o_symbol       = r_out_sym;
    assign o_overflow     = r_out_ovf;

endmodule

// ===== hw/rtl/pctd_ctrl.sv =====
// Controller of the prefix code table decoder: handshakes and scan sequencing.
module pctd_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pctd_pkg::ACTION_W-1:0]  i_action,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output pctd_pkg::t_cmd                 o_cmd,
    input  pctd_pkg::t_status              i_status
);
    import pctd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_s_tready;
    logic    r_m_tvalid;
    logic    n_m_tvalid;
    logic    w_accept;
    logic    w_out_free;
    t_action w_action;
    t_cmd    w_cmd;

    assign w_accept   = i_s_tvalid && r_s_tready;
    assign w_out_free = !r_m_tvalid || i_m_tready;
    assign w_action   = t_action'(i_action);

    // Sequence commands and next state
    always_comb begin
        w_cmd      = '0;
        n_state    = r_state;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_action)
                        ACT_LOAD:   w_cmd.load = 1'b1;
                        ACT_CLEAR:  w_cmd.clear = 1'b1;
                        ACT_DECODE: begin
                            w_cmd.start = 1'b1;
                            n_state     = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_status.match) begin
                    w_cmd.finish = 1'b1;
                    n_state      = ST_PUSH;
                end else if (i_status.scan_end) begin
                    if (i_status.at_limit) begin
                        w_cmd.finish = 1'b1;
                        n_state      = ST_PUSH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    w_cmd.rd = 1'b1;
                end
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    w_cmd.push = 1'b1;
                    n_m_tvalid = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_s_tready <= 1'b1;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s_tready <= (n_state == ST_IDLE);
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_s_tready = r_s_tready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_cmd      = w_cmd;

endmodule

// ===== hw/rtl/prefix_code_table_decoder.sv =====
// Top level of the prefix code table decoder: stream ports, controller and datapath.
// Load and clear words are handled in the idle state and may follow back to back.
// A decode word scans the table one entry per cycle through the table read port;
// its result, if any, is captured and moved to the output register once the output is free,
// and no new word is taken until the scan, and any such push, is done.
// Synchronous active-low reset empties the table, the pending code and the output.
module prefix_code_table_decoder #(
    parameter int TABLE_DEPTH  = pctd_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_CODE_LEN = pctd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // entry_index, entry_symbol, entry_code, entry_length, code_bit, zero fill
    input  logic [pctd_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // action
    input  logic [pctd_pkg::S_TUSER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // symbol
    output logic [pctd_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // symbol_valid, overflow
    output logic [pctd_pkg::M_TUSER_W-1:0]  o_m_tuser
);
    import pctd_pkg::*;

    t_cmd                w_cmd;
    t_status             w_status;
    logic                w_symbol_valid;
    logic [SYMBOL_W-1:0] w_symbol;
    logic                w_overflow;

    pctd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (i_s_tuser[ACTION_W-1:0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    pctd_datapath #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_entry_index  (i_s_tdata[5:0]),
        .i_entry_symbol (i_s_tdata[13:6]),
        .i_entry_code   (i_s_tdata[45:14]),
        .i_entry_length (i_s_tdata[51:46]),
        .i_code_bit     (i_s_tdata[52]),
        .o_symbol_valid (w_symbol_valid),
        .o_symbol       (w_symbol),
        .o_overflow     (w_overflow)
    );

    assign o_m_tdata = w_symbol;
    assign o_m_tuser = {w_overflow, w_symbol_valid};

endmodule

// ===== tb/prefix_code_table_decoder_test.sv =====
// Self-checking testbench of the prefix code table decoder stream block.
`timescale 1ns / 100ps

module prefix_code_table_decoder_test;
    import pctd_pkg::*;

    localparam int TBL_DEPTH = TABLE_DEPTH_DEF;
    localparam int MAX_LEN   = MAX_CODE_LEN_DEF;
    localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
    localparam int IDLE_PCT  = 34;
    localparam int HOLD_LEN  = 400;

    // One output word as the decoder should present it
    typedef struct packed {
        logic                symbol_valid;
        logic [SYMBOL_W-1:0] symbol;
        logic                overflow;
    } t_sym_result;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // entry_index, entry_symbol, entry_code, entry_length, code_bit, zero fill
    logic [S_TDATA_W-1:0]   i_s_tdata  = '0;
    // action
    logic [S_TUSER_W-1:0]   i_s_tuser  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // symbol
    logic [M_TDATA_W-1:0]   o_m_tdata;
    // symbol_valid, overflow
    logic [M_TUSER_W-1:0]   o_m_tuser;

    // Shadow copy of the code table and the pending code
    logic [SYMBOL_W-1:0]    tbl_sym  [TBL_DEPTH];
    logic [CODE_W-1:0]      tbl_code [TBL_DEPTH];
    logic [LEN_W-1:0]       tbl_len  [TBL_DEPTH];
    logic [CODE_W-1:0]      pend_code;
    logic [LEN_W-1:0]       pend_len;

    t_sym_result            symbol_q[$];

    int  n_words     = 0;
    int  n_loads     = 0;
    int  n_symbols   = 0;
    int  n_overflows = 0;
    int  n_mismatch  = 0;
    bit  steady      = 1'b0;
    int  stall_reqs  = 0;
    int  stall_seen  = 0;
    int  hold_left   = 0;

    prefix_code_table_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort a run that hangs
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Advance the shadow state by one accepted word and queue its result, if any
    task automatic predict_word(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                                input logic [SYMBOL_W-1:0] sym, input logic [CODE_W-1:0] code,
                                input logic [LEN_W-1:0] len, input logic cbit);
        t_sym_result r;
        bit          hit;
        hit = 1'b0;
        r   = '0;
        case (act)
            ACT_LOAD: begin
                // bits at and above the length never take part in a compare
                tbl_sym[idx]  = sym;
                tbl_code[idx] = code & CODE_W'((64'd1 << len) - 64'd1);
                tbl_len[idx]  = len;
                n_loads++;
            end
            ACT_CLEAR: begin
                pend_code = '0;
                pend_len  = '0;
            end
            ACT_DECODE: begin
                pend_code = {pend_code[CODE_W-2:0], cbit};
                pend_len  = pend_len + 1'b1;
                // lowest slot wins among equal codes
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (!hit && tbl_len[i] != 0 && tbl_len[i] <= MAX_LEN &&
                        tbl_len[i] == pend_len && tbl_code[i] == pend_code) begin
                        hit            = 1'b1;
                        r.symbol_valid = 1'b1;
                        r.symbol       = tbl_sym[i];
                    end
                end
                if (hit) begin
                    n_symbols++;
                end else if (pend_len >= MAX_LEN) begin
                    r.overflow = 1'b1;
                    n_overflows++;
                end
                if (r.symbol_valid || r.overflow) begin
                    symbol_q.push_back(r);
                    pend_code = '0;
                    pend_len  = '0;
                end
            end
            default: ;
        endcase
    endtask

    // Offer one input word, with random idle cycles ahead of it
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                             input logic [SYMBOL_W-1:0] sym, input logic [CODE_W-1:0] code,
                             input logic [LEN_W-1:0] len, input logic cbit);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {3'b000, cbit, len, code, sym, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_word(act, idx, sym, code, len, cbit);
        if (act != ACT_RESERVED) n_words++;
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [SYMBOL_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        send_word(ACT_LOAD, idx, sym, code, len, 1'($urandom));
    endtask

    task automatic send_decode(input logic cbit);
        send_word(ACT_DECODE, INDEX_W'($urandom), SYMBOL_W'($urandom), $urandom,
                  LEN_W'($urandom), cbit);
    endtask

    task automatic send_clear();
        send_word(ACT_CLEAR, INDEX_W'($urandom), SYMBOL_W'($urandom), $urandom,
                  LEN_W'($urandom), 1'($urandom));
    endtask

    // Feed the codeword bits of one slot, first bit first
    task automatic send_codeword(input int slot);
        for (int b = int'(tbl_len[slot]) - 1; b >= 0; b--) send_decode(tbl_code[slot][b]);
    endtask

    // Table extremes, masked code bits, duplicates, invalid and overlong slots
    task automatic test_directed_table();
        send_decode(1'b1);
        send_clear();
        send_load(6'd0, 8'hff, 32'hffff_fffe, 6'd1);
        send_load(6'd63, 8'h00, 32'hffff_ffff, 6'd2);
        send_load(6'd5, 8'h55, 32'h0000_0002, 6'd2);
        send_load(6'd2, 8'h22, 32'hffff_fff2, 6'd2);
        send_load(6'd10, 8'haa, 32'h0000_0000, 6'd0);
        send_load(6'd11, 8'h5a, 32'h0000_0001, 6'd33);
        send_load(6'd12, 8'h3c, 32'hffff_ffff, 6'd63);
        send_decode(1'b0);
        send_decode(1'b1);
        send_decode(1'b1);
        send_decode(1'b1);
        send_load(6'd7, 8'h77, 32'h0000_0005, 6'd3);
        send_word(ACT_RESERVED, 6'd63, 8'hff, 32'hffff_ffff, 6'd63, 1'b1);
        send_decode(1'b0);
        send_decode(1'b1);
        send_clear();
        send_decode(1'b0);
        send_load(6'd0, 8'h01, 32'h0000_0000, 6'd0);
        send_decode(1'b1);
        send_decode(1'b0);
        send_decode(1'b0);
    endtask

    // Full-length codeword matching on its last bit, a full-length overflow, then a dropped code
    task automatic test_code_limit();
        logic [CODE_W-1:0] cw;
        cw = 32'h8000_0001;
        send_load(6'd2, 8'h00, 32'h0, 6'd0);
        send_load(6'd5, 8'h00, 32'h0, 6'd0);
        send_load(6'd7, 8'h00, 32'h0, 6'd0);
        send_load(6'd63, 8'h00, 32'h0, 6'd0);
        send_load(6'd1, 8'hc3, cw, 6'd32);
        send_clear();
        for (int b = CODE_W - 1; b >= 0; b--) send_decode(cw[b]);
        for (int b = 0; b < CODE_W; b++) send_decode(1'($urandom));
        for (int b = 0; b < 16; b++) send_decode(1'($urandom));
        send_clear();
        for (int b = CODE_W - 1; b >= 0; b--) send_decode(cw[b]);
    endtask

    // Hold the output off for a long stretch so the input backs up
    task automatic test_output_stall();
        send_load(6'd0, SYMBOL_W'($urandom), 32'h0, 6'd1);
        send_load(6'd1, SYMBOL_W'($urandom), 32'h1, 6'd1);
        send_clear();
        steady = 1'b1;
        stall_reqs++;
        for (int i = 0; i < 40; i++) send_decode(1'($urandom));
    endtask

    // Random tables of mostly short codes fed with mostly whole codewords
    task automatic test_random_table();
        int               start;
        int               pick;
        int               slot;
        logic [LEN_W-1:0] len;
        start = n_words;
        steady = 1'b1;
        for (int i = 0; i < 16; i++) begin
            send_load(INDEX_W'($urandom), SYMBOL_W'($urandom), $urandom,
                      LEN_W'($urandom_range(1, 5)));
        end
        while (n_words - start < 330) begin
            if (n_words - start > 120) steady = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                case ($urandom_range(0, 9))
                    0:       len = '0;
                    1:       len = LEN_W'($urandom_range(33, 63));
                    2:       len = LEN_W'($urandom_range(6, 32));
                    default: len = LEN_W'($urandom_range(1, 5));
                endcase
                send_load(INDEX_W'($urandom), SYMBOL_W'($urandom), $urandom, len);
            end else if (pick < 80) begin
                if ($urandom_range(0, 1) == 0) send_clear();
                slot = -1;
                for (int t = 0; t < 8 && slot < 0; t++) begin
                    pick = $urandom_range(0, TBL_DEPTH - 1);
                    if (tbl_len[pick] != 0 && tbl_len[pick] <= 8) slot = pick;
                end
                if (slot >= 0) send_codeword(slot);
                else send_decode(1'($urandom));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 3)) send_decode(1'($urandom));
            end else if (pick < 95) begin
                send_clear();
            end else begin
                send_word(ACT_RESERVED, INDEX_W'($urandom), SYMBOL_W'($urandom), $urandom,
                          LEN_W'($urandom), 1'($urandom));
            end
        end
    endtask

    // Sparse table of long or invalid codes, so random bits run into the limit
    task automatic test_random_overflow();
        logic [LEN_W-1:0] len;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if ($urandom_range(0, 2) == 0) len = '0;
            else len = LEN_W'($urandom_range(20, 63));
            send_load(INDEX_W'(i), SYMBOL_W'($urandom), $urandom, len);
        end
        for (int i = 0; i < 110; i++) begin
            if ($urandom_range(0, 99) < 3) send_clear();
            else send_decode(1'($urandom));
        end
    endtask

    // Main sequence
    initial begin
        pend_code = '0;
        pend_len  = '0;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            tbl_sym[i]  = '0;
            tbl_code[i] = '0;
            tbl_len[i]  = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_table();
        test_code_limit();
        test_output_stall();
        test_random_table();
        test_random_overflow();
        i_s_tvalid <= 1'b0;
        while (symbol_q.size() != 0) @(posedge i_clk);
        repeat (TBL_DEPTH + 8) @(posedge i_clk);
        if (symbol_q.size() != 0) n_mismatch++;
        $display("Sent %0d words (%0d table loads) through the decoder.", n_words, n_loads);
        $display("Got %0d decoded symbols and %0d overflows, %0d mismatches.",
                 n_symbols, n_overflows, n_mismatch);
        if (n_mismatch == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Drive output ready: random idling, a long hold on request
    always @(posedge i_clk) begin
        if (stall_reqs != stall_seen) begin
            stall_seen = stall_reqs;
            hold_left  = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each output word against the oldest expected result
    always @(posedge i_clk) begin
        t_sym_result want;
        t_sym_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{symbol_valid: o_m_tuser[0], symbol: o_m_tdata, overflow: o_m_tuser[1]};
            if (symbol_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("%0t: unexpected word valid=%0d symbol=%02h overflow=%0d",
                             $realtime, got.symbol_valid, got.symbol, got.overflow);
            end else begin
                want = symbol_q.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"%0t: expected valid=%0d symbol=%02h overflow=%0d, ",
                                  "got valid=%0d symbol=%02h overflow=%0d"},
                                 $realtime, want.symbol_valid, want.symbol, want.overflow,
                                 got.symbol_valid, got.symbol, got.overflow);
                end
            end
        end
    end

endmodule
